[rtl/core/plist_pkg.sv]
// ============================================================================
// plist_pkg - shared definitions for the positional list engine
// Sizes, beat layouts, operation/status codes and the cell control word.
// ============================================================================
package plist_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    // Beat field widths
    localparam int MODE_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 3;
    localparam int ELEM_W   = 32;
    localparam int EIDX_W   = 4;
    localparam int COUNT_W  = 5;

    // Wide enough for position and count + 1
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // Input beat layout
    localparam int S_MODE_LSB   = 0;
    localparam int S_VALUE_LSB  = S_MODE_LSB + MODE_W;
    localparam int S_POS_LSB    = S_VALUE_LSB + VALUE_W;
    localparam int S_FIELDS_W   = S_POS_LSB + POS_W;
    localparam int S_TDATA_W    = ((S_FIELDS_W + 7) / 8) * 8;

    // Output beat layout
    localparam int M_STATUS_LSB = 0;
    localparam int M_ELEM_LSB   = M_STATUS_LSB + STATUS_W;
    localparam int M_EIDX_LSB   = M_ELEM_LSB + ELEM_W;
    localparam int M_COUNT_LSB  = M_EIDX_LSB + EIDX_W;
    localparam int M_FIELDS_W   = M_COUNT_LSB + COUNT_W;
    localparam int M_TDATA_W    = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W      = M_TDATA_W - M_FIELDS_W;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_INS_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INS_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INS_POS   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DEL_FRONT = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DEL_BACK  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_DEL_POS   = 3'd5;
    localparam logic [MODE_W-1:0] MODE_LIST      = 3'd6;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_DONE    = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_IGNORED = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_LISTED  = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_EMPTY   = 3'd4;

    typedef logic [DATA_WIDTH-1:0] data_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INS,
        CELL_DEL,
        CELL_ROT
    } cell_op_t;

    typedef struct packed {
        cell_op_t         op;
        logic [IDX_W-1:0] pos;   // target slot for insert / delete
        logic [IDX_W-1:0] tail;  // last occupied slot, for rotate
    } cell_ctrl_t;

endpackage

[rtl/core/plist_cell.sv]
// ============================================================================
// plist_cell - one storage slot of the list
// Holds one word; each cycle keeps it or takes a neighbor's, the head slot's
// or the inserted word, by the broadcast control and its own slot index.
// ============================================================================
module plist_cell (
    input  logic                          aclk,
    input  logic [plist_pkg::IDX_W-1:0]   cell_idx,
    input  plist_pkg::cell_ctrl_t         ctrl,
    input  plist_pkg::data_t              ins_data,
    input  plist_pkg::data_t              left_data,
    input  plist_pkg::data_t              right_data,
    input  plist_pkg::data_t              head_data,
    output plist_pkg::data_t              q
);
    import plist_pkg::*;

    data_t data_reg;
    data_t data_next;

    always_comb begin
        data_next = data_reg;
        case (ctrl.op)
            CELL_INS: begin
                if (cell_idx > ctrl.pos) begin
                    data_next = left_data;
                end else if (cell_idx == ctrl.pos) begin
                    data_next = ins_data;
                end
            end
            CELL_DEL: begin
                if (cell_idx >= ctrl.pos) begin
                    data_next = right_data;
                end
            end
            CELL_ROT: begin
                // occupied slots rotate toward the head
                if (cell_idx < ctrl.tail) begin
                    data_next = right_data;
                end else if (cell_idx == ctrl.tail) begin
                    data_next = head_data;
                end
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

[rtl/core/plist_chain.sv]
// ============================================================================
// plist_chain - row of list cells
// Wires each cell to its left and right neighbor and to the head slot.
// ============================================================================
module plist_chain (
    input  logic                  aclk,
    input  plist_pkg::cell_ctrl_t ctrl,
    input  plist_pkg::data_t      ins_data,
    output plist_pkg::data_t      cells [plist_pkg::CAPACITY]
);
    import plist_pkg::*;

    data_t cell_q [CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        data_t left_d;
        data_t right_d;

        if (i == 0) begin : g_first
            assign left_d = '0;
        end else begin : g_mid_l
            assign left_d = cell_q[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_d = '0;
        end else begin : g_mid_r
            assign right_d = cell_q[i+1];
        end

        plist_cell u_cell (
            .aclk       (aclk),
            .cell_idx   (IDX_W'(i)),
            .ctrl       (ctrl),
            .ins_data   (ins_data),
            .left_data  (left_d),
            .right_data (right_d),
            .head_data  (cell_q[0]),
            .q          (cell_q[i])
        );

        assign cells[i] = cell_q[i];
    end

endmodule

[rtl/core/positional_list_engine_unit.sv]
// ============================================================================
// positional_list_engine_unit - ordered list with positional insert/delete
// Command beats edit or list a word list kept in a row of shifting cells.
// ============================================================================
//  channel | dir | tdata (low bit up)                          | tlast
//  s_      | in  | mode[2:0] value[34:3] position[40:35]        | -
//  m_      | out | status[2:0] element[34:3] index[38:35]      | last result
//          |     | count[43:39]                                |
//
//  Insert/delete/bad commands and List of an empty list: one result beat;
//  all cells shift together in the accept cycle.
//  List of a non-empty list: the accept cycle starts the walk, then one
//  result beat per cycle while m_ is not stalled, from the head cell while
//  the occupied cells rotate; input is held off until the walk ends.
//  Reset clears the count and the control state; cell contents are kept.
//  A stalled m_ side holds the result register; the next command is taken
//  as soon as that register is free or being drained.
// ============================================================================
module positional_list_engine_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [plist_pkg::S_TDATA_W-1:0]   s_tdata,  // mode, value, position
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [plist_pkg::M_TDATA_W-1:0]   m_tdata,  // status, element,
                                                        // element_index, count
    output logic                              m_tlast
);
    import plist_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_LIST
    } state_t;

    state_t               state_reg,    state_next;
    logic [CNT_W-1:0]     count_reg,    count_next;
    logic [IDX_W-1:0]     list_idx_reg, list_idx_next;
    logic                 m_valid_reg,  m_valid_next;
    logic [STATUS_W-1:0]  m_status_reg, m_status_next;
    logic [ELEM_W-1:0]    m_elem_reg,   m_elem_next;
    logic [EIDX_W-1:0]    m_eidx_reg,   m_eidx_next;
    logic [COUNT_W-1:0]   m_count_reg,  m_count_next;
    logic                 m_last_reg,   m_last_next;

    logic [MODE_W-1:0]    in_mode;
    logic [VALUE_W-1:0]   in_value;
    logic [POS_W-1:0]     in_pos;
    logic                 out_free;
    logic                 accept;
    logic                 full;
    logic                 ins_ok;
    logic                 del_ok;
    logic [CMP_W-1:0]     pos_ext;
    logic [CMP_W-1:0]     cnt_ext;
    logic [IDX_W-1:0]     tail_idx;
    cell_ctrl_t           ctrl;
    data_t                ins_data;
    data_t                cells [CAPACITY];

    assign in_mode  = s_tdata[S_MODE_LSB  +: MODE_W];
    assign in_value = s_tdata[S_VALUE_LSB +: VALUE_W];
    assign in_pos   = s_tdata[S_POS_LSB   +: POS_W];
    assign ins_data = DATA_WIDTH'(in_value);

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign pos_ext  = CMP_W'(in_pos);
    assign cnt_ext  = CMP_W'(count_reg);
    assign tail_idx = IDX_W'(count_reg - CNT_W'(1));
    assign ins_ok   = (pos_ext != '0) && (pos_ext <= cnt_ext + CMP_W'(1));
    assign del_ok   = (pos_ext != '0) && (pos_ext <= cnt_ext);

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        list_idx_next = list_idx_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_elem_next   = m_elem_reg;
        m_eidx_next   = m_eidx_reg;
        m_count_next  = m_count_reg;
        m_last_next   = m_last_reg;
        ctrl.op       = CELL_HOLD;
        ctrl.pos      = '0;
        ctrl.tail     = tail_idx;

        if (accept) begin
            m_valid_next  = 1'b1;
            m_status_next = STAT_IGNORED;
            m_elem_next   = '0;
            m_eidx_next   = '0;
            m_last_next   = 1'b1;

            case (in_mode)
                MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_POS: begin
                    if (in_mode == MODE_INS_FRONT) begin
                        ctrl.pos = '0;
                    end else if (in_mode == MODE_INS_BACK) begin
                        ctrl.pos = IDX_W'(count_reg);
                    end else begin
                        ctrl.pos = IDX_W'(pos_ext - CMP_W'(1));
                    end
                    // position is checked before the full condition
                    if (in_mode == MODE_INS_POS && !ins_ok) begin
                        m_status_next = STAT_IGNORED;
                    end else if (full) begin
                        m_status_next = STAT_FULL;
                    end else begin
                        ctrl.op       = CELL_INS;
                        count_next    = count_reg + CNT_W'(1);
                        m_status_next = STAT_DONE;
                    end
                end
                MODE_DEL_FRONT, MODE_DEL_BACK: begin
                    ctrl.pos = (in_mode == MODE_DEL_FRONT) ? '0 : tail_idx;
                    if (count_reg == '0) begin
                        m_status_next = STAT_EMPTY;
                    end else begin
                        ctrl.op       = CELL_DEL;
                        count_next    = count_reg - CNT_W'(1);
                        m_status_next = STAT_DONE;
                    end
                end
                MODE_DEL_POS: begin
                    ctrl.pos = IDX_W'(pos_ext - CMP_W'(1));
                    if (del_ok) begin
                        ctrl.op       = CELL_DEL;
                        count_next    = count_reg - CNT_W'(1);
                        m_status_next = STAT_DONE;
                    end
                end
                MODE_LIST: begin
                    if (count_reg == '0) begin
                        m_status_next = STAT_EMPTY;
                    end else begin
                        // beats come from the list walk instead
                        m_valid_next  = m_valid_reg && !m_tready;
                        m_status_next = m_status_reg;
                        m_elem_next   = m_elem_reg;
                        m_eidx_next   = m_eidx_reg;
                        m_last_next   = m_last_reg;
                        list_idx_next = '0;
                        state_next    = ST_LIST;
                    end
                end
                default: begin
                    m_status_next = STAT_IGNORED;
                end
            endcase
            if (!(in_mode == MODE_LIST && count_reg != '0)) begin
                m_count_next = COUNT_W'(count_next);
            end
        end else if (state_reg == ST_LIST && out_free) begin
            ctrl.op       = CELL_ROT;
            m_valid_next  = 1'b1;
            m_status_next = STAT_LISTED;
            m_elem_next   = ELEM_W'(cells[0]);
            m_eidx_next   = EIDX_W'(list_idx_reg);
            m_count_next  = COUNT_W'(count_reg);
            m_last_next   = (list_idx_reg == tail_idx);
            list_idx_next = list_idx_reg + IDX_W'(1);
            if (list_idx_reg == tail_idx) begin
                state_next = ST_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            list_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            list_idx_reg <= list_idx_next;
            m_valid_reg  <= m_valid_next;
        end
        m_status_reg <= m_status_next;
        m_elem_reg   <= m_elem_next;
        m_eidx_reg   <= m_eidx_next;
        m_count_reg  <= m_count_next;
        m_last_reg   <= m_last_next;
    end

    plist_chain u_chain (
        .aclk     (aclk),
        .ctrl     (ctrl),
        .ins_data (ins_data),
        .cells    (cells)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, m_count_reg, m_eidx_reg, m_elem_reg, m_status_reg};
    assign m_tlast  = m_last_reg;

endmodule

[rtl/core/plist_checker.sv]
// ============================================================================
// plist_checker - port-level checks for the positional list engine
// Watches the stream ports only; attached to the top level by bind.
// ============================================================================
module plist_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [plist_pkg::S_TDATA_W-1:0]   s_tdata,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [plist_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic                              m_tlast
);
    import plist_pkg::*;

    logic [STATUS_W-1:0] m_status;
    logic [COUNT_W-1:0]  m_count;

    assign m_status = m_tdata[M_STATUS_LSB +: STATUS_W];
    assign m_count  = m_tdata[M_COUNT_LSB  +: COUNT_W];

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed under stall");

    // reported count never exceeds the list capacity
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (int'(m_count) <= CAPACITY))
        else $error("count beyond capacity");

    // only listing beats may leave the run open
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_status != STAT_LISTED) |-> m_tlast)
        else $error("non-listing result without last");

    // no new command while a listing is still running
    a_list_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_status == STAT_LISTED) && !m_tlast |-> !s_tready)
        else $error("command accepted during listing");

    // a listing with more to come keeps the same count on the next beat
    a_list_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && (m_status == STAT_LISTED) && !m_tlast ##1 m_tvalid
        |-> (m_status == STAT_LISTED) && (m_count == $past(m_count)))
        else $error("listing beat out of sequence");

endmodule

bind positional_list_engine_unit plist_checker u_plist_checker (.*);

[dv/tb_top.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb_top - positional list engine testbench
// Drives edit and list commands through the s_ stream, predicts every result
// beat from a shadow copy of the list and checks the m_ stream field by field
// under several sender-idle / receiver-stall mixes, with one long hold-off.
// ============================================================================
module tb_top;
    import plist_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
    localparam int RANDOM_CMDS  = 460;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [ELEM_W-1:0]   element;
        logic [EIDX_W-1:0]   eidx;
        logic [COUNT_W-1:0]  count;
        logic                last;
    } result_t;

    // Shadow list plus the queue of result beats it has produced
    class list_tracker;
        data_t   cells[CAPACITY];
        int      n;
        result_t pending_q[$];
        int      errs;
        int      n_cmds;
        int      n_beats;
        int      status_hits[5];

        function int pending();
            return pending_q.size();
        endfunction

        function void report_mismatch(string msg);
            errs++;
            if (errs <= 40)
                $display("%0t mismatch: %s", $realtime, msg);
        endfunction

        function void push_result(logic [STATUS_W-1:0] st, data_t elem,
                                  logic [EIDX_W-1:0] idx, logic last);
            result_t r;
            r.status  = st;
            r.element = elem;
            r.eidx    = idx;
            r.count   = COUNT_W'(n);
            r.last    = last;
            pending_q.push_back(r);
        endfunction

        // position is checked before the full condition
        function logic [STATUS_W-1:0] insert_at(data_t value, int p);
            if (p < 1 || p > n + 1)
                return STAT_IGNORED;
            if (n >= CAPACITY)
                return STAT_FULL;
            for (int i = n; i > p - 1; i--)
                cells[i] = cells[i-1];
            cells[p-1] = value;
            n++;
            return STAT_DONE;
        endfunction

        function logic [STATUS_W-1:0] delete_at(int p);
            if (p < 1 || p > n)
                return STAT_IGNORED;
            for (int i = p - 1; i + 1 < n; i++)
                cells[i] = cells[i+1];
            n--;
            return STAT_DONE;
        endfunction

        function void apply_command(logic [MODE_W-1:0] mode, data_t value,
                                    logic [POS_W-1:0] pos);
            logic [STATUS_W-1:0] st;
            n_cmds++;
            case (mode)
                MODE_INS_FRONT: st = insert_at(value, 1);
                MODE_INS_BACK:  st = insert_at(value, n + 1);
                MODE_INS_POS:   st = insert_at(value, int'(pos));
                MODE_DEL_FRONT: st = (n == 0) ? STAT_EMPTY : delete_at(1);
                MODE_DEL_BACK:  st = (n == 0) ? STAT_EMPTY : delete_at(n);
                MODE_DEL_POS:   st = delete_at(int'(pos));
                MODE_LIST: begin
                    if (n == 0)
                        push_result(STAT_EMPTY, '0, '0, 1'b1);
                    else
                        for (int i = 0; i < n; i++)
                            push_result(STAT_LISTED, cells[i], EIDX_W'(i), i == n - 1);
                    return;
                end
                default:        st = STAT_IGNORED;
            endcase
            push_result(st, '0, '0, 1'b1);
        endfunction

        function void check_beat(logic [STATUS_W-1:0] st, logic [ELEM_W-1:0] elem,
                                 logic [EIDX_W-1:0] idx, logic [COUNT_W-1:0] cnt,
                                 logic last);
            result_t r;
            n_beats++;
            if (pending_q.size() == 0) begin
                report_mismatch($sformatf("unexpected beat status=%0d", st));
                return;
            end
            r = pending_q.pop_front();
            if (r.status < 5)
                status_hits[r.status]++;
            if (st !== r.status)
                report_mismatch($sformatf("status got %0d want %0d", st, r.status));
            if (elem !== r.element)
                report_mismatch($sformatf("element got %h want %h", elem, r.element));
            if (idx !== r.eidx)
                report_mismatch($sformatf("index got %0d want %0d", idx, r.eidx));
            if (cnt !== r.count)
                report_mismatch($sformatf("count got %0d want %0d", cnt, r.count));
            if (last !== r.last)
                report_mismatch($sformatf("last got %b want %b", last, r.last));
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;

    list_tracker tracker;
    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    bit  hold_req       = 1'b0;
    logic holding       = 1'b0;
    int  cycles         = 0;

    positional_list_engine_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("[positional_list_engine_unit] ERROR");
            $finish;
        end
    end

    // result side: check accepted beats, then pick next tready
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_beat(m_tdata[M_STATUS_LSB +: STATUS_W],
                               m_tdata[M_ELEM_LSB +: ELEM_W],
                               m_tdata[M_EIDX_LSB +: EIDX_W],
                               m_tdata[M_COUNT_LSB +: COUNT_W], m_tlast);
        m_tready <= !holding && ($urandom_range(99) >= recv_stall_pct);
    end

    // long receiver hold-off so the block backs up into s_tready
    initial begin
        @(posedge aclk iff hold_req);
        holding <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        holding <= 1'b0;
    end

    task automatic send_cmd(input logic [MODE_W-1:0] mode, input data_t value,
                            input logic [POS_W-1:0] pos);
        logic [S_TDATA_W-1:0] beat;
        beat = '0;
        beat[S_MODE_LSB +: MODE_W]   = mode;
        beat[S_VALUE_LSB +: VALUE_W] = value;
        beat[S_POS_LSB +: POS_W]     = pos;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        do @(posedge aclk); while (!s_tready);
        tracker.apply_command(mode, value, pos);
    endtask

    // mostly legal edits steered toward a moving fill target, some lists and noise
    task automatic run_random(input int n_items, input int hold_at);
        int r;
        int c;
        int target;
        logic [MODE_W-1:0] mode;
        logic [POS_W-1:0]  pos;
        target = 8;
        for (int k = 0; k < n_items; k++) begin
            if (k == hold_at)
                hold_req = 1'b1;
            if (k % 30 == 0)
                target = ($urandom_range(3) == 0) ? ($urandom_range(1) ? CAPACITY : 0)
                                                  : $urandom_range(CAPACITY);
            c   = tracker.n;
            r   = $urandom_range(99);
            pos = POS_W'($urandom_range(63));
            if (r < 3) begin
                mode = MODE_W'($urandom_range(7));
            end else if (r < 12) begin
                mode = MODE_LIST;
            end else if ((c < target) ? (r < 72) : (r < 30)) begin
                case ($urandom_range(2))
                    0:       mode = MODE_INS_FRONT;
                    1:       mode = MODE_INS_BACK;
                    default: begin
                        mode = MODE_INS_POS;
                        if ($urandom_range(9) != 0)
                            pos = POS_W'($urandom_range(1, c + 1));
                    end
                endcase
            end else begin
                case ($urandom_range(2))
                    0:       mode = MODE_DEL_FRONT;
                    1:       mode = MODE_DEL_BACK;
                    default: begin
                        mode = MODE_DEL_POS;
                        if ($urandom_range(9) != 0)
                            pos = POS_W'($urandom_range(1, (c > 0) ? c : 1));
                    end
                endcase
            end
            send_cmd(mode, $urandom, pos);
        end
    endtask

    initial begin
        tracker = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty list corners
        send_idle_pct  = 7;
        recv_stall_pct = 7;
        send_cmd(MODE_LIST, 32'h0, 6'd0);
        send_cmd(MODE_DEL_FRONT, 32'h0, 6'd0);
        send_cmd(MODE_DEL_BACK, 32'h0, 6'd0);
        send_cmd(MODE_DEL_POS, 32'h0, 6'd1);
        send_cmd(MODE_INS_POS, 32'h1234_5678, 6'd0);
        send_cmd(MODE_INS_POS, 32'h1234_5678, 6'd2);
        send_cmd(MODE_INS_POS, 32'hFFFF_FFFF, 6'd63);
        send_cmd(MODE_UNUSED, 32'hFFFF_FFFF, 6'd63);
        // build up, fill to capacity, then probe the full list, list it and delete
        send_cmd(MODE_INS_FRONT, 32'hFFFF_FFFF, 6'd0);
        send_cmd(MODE_INS_BACK, 32'h0000_0000, 6'd0);
        send_cmd(MODE_INS_POS, 32'hA5A5_5A5A, 6'd2);
        send_cmd(MODE_INS_POS, 32'h8000_0001, 6'd4);
        for (int i = 4; i < CAPACITY; i++)
            send_cmd(MODE_INS_BACK, $urandom, 6'd0);
        send_cmd(MODE_INS_FRONT, 32'hDEAD_BEEF, 6'd0);
        send_cmd(MODE_INS_POS, 32'hDEAD_BEEF, 6'd17);
        send_cmd(MODE_INS_POS, 32'hDEAD_BEEF, 6'd18);
        send_cmd(MODE_LIST, 32'h0, 6'd0);
        send_cmd(MODE_DEL_POS, 32'h0, 6'd17);
        send_cmd(MODE_DEL_POS, 32'h0, 6'd16);
        send_cmd(MODE_DEL_POS, 32'h0, 6'd3);
        send_cmd(MODE_DEL_FRONT, 32'h0, 6'd0);
        send_cmd(MODE_DEL_BACK, 32'h0, 6'd0);
        send_cmd(MODE_LIST, 32'h0, 6'd0);

        // random phases: none, sender idle, receiver stall, both light
        send_idle_pct = 0;  recv_stall_pct = 0;
        run_random(RANDOM_CMDS / 4, 20);
        send_idle_pct = 60; recv_stall_pct = 0;
        run_random(RANDOM_CMDS / 4, -1);
        send_idle_pct = 0;  recv_stall_pct = 60;
        run_random(RANDOM_CMDS / 4, -1);
        send_idle_pct = 7;  recv_stall_pct = 7;
        run_random(RANDOM_CMDS / 4, -1);
        s_tvalid <= 1'b0;

        recv_stall_pct = 0;
        while (tracker.pending() != 0 || holding)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d commands and %0d result beats", tracker.n_cmds,
                 tracker.n_beats);
        $display("beats by status: done %0d, ignored %0d, full %0d, listed %0d, empty %0d",
                 tracker.status_hits[0], tracker.status_hits[1], tracker.status_hits[2],
                 tracker.status_hits[3], tracker.status_hits[4]);
        if (tracker.errs == 0 && tracker.pending() == 0)
            $display("[positional_list_engine_unit] OK");
        else
            $display("[positional_list_engine_unit] ERROR");
        $finish;
    end

endmodule

[positional_list_engine_unit.f]
rtl/core/plist_pkg.sv
rtl/core/plist_cell.sv
rtl/core/plist_chain.sv
rtl/core/positional_list_engine_unit.sv
rtl/core/plist_checker.sv
dv/tb_top.sv
